FILE: rtl/core/bis_pkg.sv
// Shared constants, types and codes of the bilinear image scaler.
// No dependencies; every other file of the block but bis_div imports it.
package bis_pkg;

  // Fixed-point position format: FRAC_BITS fractional bits.
  localparam int FRAC_BITS = 12;
  localparam int FRAC_ONE  = 1 << FRAC_BITS;

  // Largest target size; larger register values act as this.
  localparam int DST_MAX_DIM = 1024;

  // Default source store size.
  localparam int SRC_MAX_W_DEF = 256;
  localparam int SRC_MAX_H_DEF = 256;

  // Field widths.
  localparam int POS_W     = 10;
  localparam int PIX_W     = 32;
  localparam int LANE_W    = 8;
  localparam int LANES     = PIX_W / LANE_W;
  localparam int SRC_REG_W = 9;
  localparam int DST_REG_W = 11;
  localparam int CFG_W     = 11;

  // Bilinear weight: product of two terms, each f or (FRAC_ONE - f), up to FRAC_ONE squared.
  localparam int WGT_W = 2 * FRAC_BITS + 1;

  // Command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SRC_W,
    REG_SRC_H,
    REG_DST_W,
    REG_DST_H
  } cfg_idx_t;

  typedef logic [PIX_W-1:0]           pixel_t;
  typedef logic [3:0][PIX_W-1:0]      quad_t;
  typedef logic [3:0][WGT_W-1:0]      wquad_t;

  // Control that travels with an item through the blend stages.
  typedef struct packed {
    logic valid;
    logic err;
  } blend_ctl_t;

endpackage

FILE: rtl/core/bis_in_if.sv
// Input channel of the bilinear image scaler: valid/ready and one command.
// Depends on bis_pkg.
interface bis_in_if;
  import bis_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [PIX_W-1:0]     pixel_in;

  modport source (output valid, command, pos_x, pos_y, pixel_in, input ready);
  modport sink   (input valid, command, pos_x, pos_y, pixel_in, output ready);
endinterface

FILE: rtl/core/bis_out_if.sv
// Result channel of the bilinear image scaler: valid/ready and one pixel.
// Depends on bis_pkg.
interface bis_out_if;
  import bis_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     pixel_out;
  logic                 error;

  modport source (output valid, pixel_out, error, input ready);
  modport sink   (input valid, pixel_out, error, output ready);
endinterface

FILE: rtl/core/bilinear_image_scaler_top.sv
// Top level of the bilinear image scaler: configuration, position pipeline,
// source store and blend. Depends on bis_pkg, bis_in_if, bis_out_if,
// bis_div, bis_store and bis_blend.
//
//   channel   direction  transaction                       handshake
//   in_ch     in         load or render command            valid / ready
//   out_ch    out        interpolated pixel and error flag valid / ready
//   cfg_*     in         register write (index, data)      cfg_we, no wait
//
// One transaction per cycle is taken while in_ch.ready is high; a render
// result is presented after five register stages (input, position
// multiply, address and weights with the store read, lane products, sum and
// round). Loads give no result.
// After reset and after every register write the two step dividers start
// and work out their quotients one bit at a time; in_ch.ready stays low
// until both are done.
// The whole pipeline advances together whenever the output register is empty
// or being taken; a stall freezes every stage, store read included.
// The store has no clearing pass: entries are undefined until loaded.
module bilinear_image_scaler_top #(
  parameter int SRC_MAX_W = bis_pkg::SRC_MAX_W_DEF,
  parameter int SRC_MAX_H = bis_pkg::SRC_MAX_H_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  bis_pkg::cfg_idx_t         cfg_index,
  input  logic [bis_pkg::CFG_W-1:0] cfg_wdata,
  bis_in_if.sink                    in_ch,
  bis_out_if.source                 out_ch
);
  import bis_pkg::*;

  localparam int SWW = $clog2(SRC_MAX_W + 1);
  localparam int SHW = $clog2(SRC_MAX_H + 1);
  localparam int IXW = $clog2(SRC_MAX_W);
  localparam int IYW = $clog2(SRC_MAX_H);
  localparam int SXW = IXW + FRAC_BITS;
  localparam int SYW = IYW + FRAC_BITS;
  localparam int QXW = $clog2(SRC_MAX_W * FRAC_ONE + 1);
  localparam int QYW = $clog2(SRC_MAX_H * FRAC_ONE + 1);
  localparam int MXW = QXW + POS_W;
  localparam int MYW = QYW + POS_W;
  localparam int FW  = FRAC_BITS + 1;
  localparam int MW  = 2 * FW;
  localparam logic [FW-1:0] FRAC_ONE_V = FW'(FRAC_ONE);

  // ---------------------------------------------------------------------
  // Configuration registers; out-of-range sizes are clamped when used.
  // ---------------------------------------------------------------------
  logic [SRC_REG_W-1:0] src_w_r;
  logic [SRC_REG_W-1:0] src_h_r;
  logic [DST_REG_W-1:0] dst_w_r;
  logic [DST_REG_W-1:0] dst_h_r;
  logic                 div_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= SRC_REG_W'(1);
      src_h_r  <= SRC_REG_W'(1);
      dst_w_r  <= DST_REG_W'(1);
      dst_h_r  <= DST_REG_W'(1);
      div_go_r <= 1'b1;
    end else begin
      div_go_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC_W: src_w_r <= cfg_wdata[SRC_REG_W-1:0];
          REG_SRC_H: src_h_r <= cfg_wdata[SRC_REG_W-1:0];
          REG_DST_W: dst_w_r <= cfg_wdata[DST_REG_W-1:0];
          REG_DST_H: dst_h_r <= cfg_wdata[DST_REG_W-1:0];
        endcase
      end
    end
  end

  logic [SWW-1:0]       sw_eff;
  logic [SHW-1:0]       sh_eff;
  logic [DST_REG_W-1:0] tw_eff;
  logic [DST_REG_W-1:0] th_eff;

  // Zero acts as one; anything above the maximum acts as the maximum.
  always_comb begin
    if (src_w_r == '0) begin
      sw_eff = SWW'(1);
    end else if (32'(src_w_r) > SRC_MAX_W) begin
      sw_eff = SWW'(SRC_MAX_W);
    end else begin
      sw_eff = SWW'(src_w_r);
    end
    if (src_h_r == '0) begin
      sh_eff = SHW'(1);
    end else if (32'(src_h_r) > SRC_MAX_H) begin
      sh_eff = SHW'(SRC_MAX_H);
    end else begin
      sh_eff = SHW'(src_h_r);
    end
    if (dst_w_r == '0) begin
      tw_eff = DST_REG_W'(1);
    end else if (32'(dst_w_r) > DST_MAX_DIM) begin
      tw_eff = DST_REG_W'(DST_MAX_DIM);
    end else begin
      tw_eff = dst_w_r;
    end
    if (dst_h_r == '0) begin
      th_eff = DST_REG_W'(1);
    end else if (32'(dst_h_r) > DST_MAX_DIM) begin
      th_eff = DST_REG_W'(DST_MAX_DIM);
    end else begin
      th_eff = dst_h_r;
    end
  end

  // ---------------------------------------------------------------------
  // Step dividers: step = source size * FRAC_ONE / target size, truncated.
  // ---------------------------------------------------------------------
  logic [QXW-1:0] step_x;
  logic [QYW-1:0] step_y;
  logic           busy_x;
  logic           busy_y;
  logic           div_busy;

  bis_div #(.NUM_W(QXW), .DEN_W(DST_REG_W)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (QXW'(32'(sw_eff) << FRAC_BITS)),
    .divisor  (tw_eff),
    .busy     (busy_x),
    .quotient (step_x)
  );

  bis_div #(.NUM_W(QYW), .DEN_W(DST_REG_W)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (QYW'(32'(sh_eff) << FRAC_BITS)),
    .divisor  (th_eff),
    .busy     (busy_y),
    .quotient (step_y)
  );

  assign div_busy = div_go_r | busy_x | busy_y;

  // ---------------------------------------------------------------------
  // Pipeline control: advance everything while the output can move.
  // ---------------------------------------------------------------------
  blend_ctl_t out_ctl;
  logic       adv;
  logic       in_take;

  assign adv         = !out_ctl.valid || out_ch.ready;
  assign in_ch.ready = adv && !div_busy;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Stage 1: hold the accepted transaction.
  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [POS_W-1:0] s1_px_r;
  logic [POS_W-1:0] s1_py_r;
  pixel_t           s1_pix_r;

  // Stage 2: source position and range check.
  logic             s2_valid_r;
  logic             s2_cmd_r;
  logic             s2_err_r;
  logic [SXW-1:0]   s2_sx_r;
  logic [SYW-1:0]   s2_sy_r;
  logic [POS_W-1:0] s2_px_r;
  logic [POS_W-1:0] s2_py_r;
  pixel_t           s2_pix_r;

  // Stage 3: weights and neighbour parities; store data registered in bis_store.
  blend_ctl_t       s3_ctl_r;
  wquad_t           s3_wgt_r;
  logic             s3_ix0_r;
  logic             s3_nx0_r;
  logic             s3_iy0_r;
  logic             s3_ny0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_ctl_r   <= '0;
    end else if (adv) begin
      s1_valid_r     <= in_take;
      s2_valid_r     <= s1_valid_r;
      // Only renders go on; loads end at the store write.
      s3_ctl_r.valid <= s2_valid_r && (s2_cmd_r == CMD_RENDER);
      s3_ctl_r.err   <= s2_err_r;
    end
  end

  // Stage 1 -> 2: position multiply and bounds check.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= in_ch.command;
      s1_px_r  <= in_ch.pos_x;
      s1_py_r  <= in_ch.pos_y;
      s1_pix_r <= in_ch.pixel_in;

      s2_cmd_r <= s1_cmd_r;
      s2_px_r  <= s1_px_r;
      s2_py_r  <= s1_py_r;
      s2_pix_r <= s1_pix_r;
      s2_err_r <= (32'(s1_px_r) >= 32'(tw_eff)) || (32'(s1_py_r) >= 32'(th_eff));
      s2_sx_r  <= SXW'(MXW'(step_x) * MXW'(s1_px_r));
      s2_sy_r  <= SYW'(MYW'(step_y) * MYW'(s1_py_r));
    end
  end

  // Stage 2 -> 3: split position, clamp right and lower neighbours, weights.
  logic [IXW-1:0]       ix;
  logic [IXW-1:0]       nx;
  logic [IYW-1:0]       iy;
  logic [IYW-1:0]       ny;
  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic [FW-1:0]        omfx;
  logic [FW-1:0]        omfy;
  logic                 st_we;

  assign ix   = s2_sx_r[SXW-1:FRAC_BITS];
  assign iy   = s2_sy_r[SYW-1:FRAC_BITS];
  assign fx   = s2_sx_r[FRAC_BITS-1:0];
  assign fy   = s2_sy_r[FRAC_BITS-1:0];
  assign nx   = (32'(ix) + 1 >= 32'(sw_eff)) ? ix : IXW'(32'(ix) + 1);
  assign ny   = (32'(iy) + 1 >= 32'(sh_eff)) ? iy : IYW'(32'(iy) + 1);
  assign omfx = FRAC_ONE_V - {1'b0, fx};
  assign omfy = FRAC_ONE_V - {1'b0, fy};

  // Drop loads that fall outside the store.
  assign st_we = s2_valid_r && (s2_cmd_r == CMD_LOAD)
              && (32'(s2_px_r) < SRC_MAX_W) && (32'(s2_py_r) < SRC_MAX_H);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_wgt_r[0] <= WGT_W'(MW'(omfx) * MW'(omfy));
      s3_wgt_r[1] <= WGT_W'(MW'(fx) * MW'(omfy));
      s3_wgt_r[2] <= WGT_W'(MW'(omfx) * MW'(fy));
      s3_wgt_r[3] <= WGT_W'(MW'(fx) * MW'(fy));
      s3_ix0_r    <= ix[0];
      s3_nx0_r    <= nx[0];
      s3_iy0_r    <= iy[0];
      s3_ny0_r    <= ny[0];
    end
  end

  // Loads write from the same stage in which renders read, so the
  // store sees transactions in order.
  quad_t bank_rd;

  bis_store #(
    .SRC_MAX_W (SRC_MAX_W),
    .SRC_MAX_H (SRC_MAX_H),
    .IXW       (IXW),
    .IYW       (IYW)
  ) u_store (
    .clk   (clk),
    .en    (adv),
    .we    (st_we),
    .wcol  (s2_px_r),
    .wrow  (s2_py_r),
    .wdata (s2_pix_r),
    .col_a (ix),
    .col_b (nx),
    .row_a (iy),
    .row_b (ny),
    .rdata (bank_rd)
  );

  // Route banks back to neighbour order: top-left, top-right, lower-left,
  // lower-right.
  quad_t nbr;

  assign nbr[0] = bank_rd[{s3_iy0_r, s3_ix0_r}];
  assign nbr[1] = bank_rd[{s3_iy0_r, s3_nx0_r}];
  assign nbr[2] = bank_rd[{s3_ny0_r, s3_ix0_r}];
  assign nbr[3] = bank_rd[{s3_ny0_r, s3_nx0_r}];

  // ---------------------------------------------------------------------
  // Blend and output register.
  // ---------------------------------------------------------------------
  pixel_t out_pixel;

  bis_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .ctl_in  (s3_ctl_r),
    .wgt     (s3_wgt_r),
    .pix     (nbr),
    .ctl_out (out_ctl),
    .pixel   (out_pixel)
  );

  assign out_ch.valid     = out_ctl.valid;
  assign out_ch.pixel_out = out_pixel;
  assign out_ch.error     = out_ctl.err;

endmodule

FILE: rtl/core/bis_div.sv
// Restoring divider, one quotient bit per cycle, for the position steps.
// Depends on nothing but its parameters.
module bis_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial    = {rem_r, num_r[NUM_W-1]};
  assign fits     = trial >= {1'b0, den_r};
  assign busy     = cnt_r != '0;
  assign quotient = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Shift quotient bits in from the bottom as the dividend leaves the top.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/core/bis_store.sv
// Source pixel store in four banks split by column and row parity.
// Depends on bis_pkg. One write and one registered read per bank each cycle while en is high.
module bis_store #(
  parameter int SRC_MAX_W = bis_pkg::SRC_MAX_W_DEF,
  parameter int SRC_MAX_H = bis_pkg::SRC_MAX_H_DEF,
  parameter int IXW       = $clog2(SRC_MAX_W),
  parameter int IYW       = $clog2(SRC_MAX_H)
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [bis_pkg::POS_W-1:0] wcol,
  input  logic [bis_pkg::POS_W-1:0] wrow,
  input  bis_pkg::pixel_t           wdata,
  input  logic [IXW-1:0]            col_a,
  input  logic [IXW-1:0]            col_b,
  input  logic [IYW-1:0]            row_a,
  input  logic [IYW-1:0]            row_b,
  output bis_pkg::quad_t            rdata
);
  import bis_pkg::*;

  localparam int BW  = (SRC_MAX_W + 1) / 2;
  localparam int BH  = (SRC_MAX_H + 1) / 2;
  localparam int BD  = BW * BH;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

  logic [BAW-1:0] waddr;
  logic [1:0]     wbank;

  assign waddr = BAW'(32'(wrow >> 1) * BW + 32'(wcol >> 1));
  assign wbank = {wrow[0], wcol[0]};

  // Bank index is {row parity, column parity}. The neighbour columns differ in
  // parity unless clamped, in which case both are the same column.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [BD];
    logic [PIX_W-1:0] rd_r;
    logic [IXW-1:0]   col;
    logic [IYW-1:0]   row;
    logic [BAW-1:0]   raddr;

    assign col   = (col_a[0] == 1'(b % 2)) ? col_a : col_b;
    assign row   = (row_a[0] == 1'(b / 2)) ? row_a : row_b;
    assign raddr = BAW'(32'(row >> 1) * BW + 32'(col >> 1));

    always_ff @(posedge clk) begin
      if (en && we && (wbank == 2'(b))) begin
        mem[waddr] <= wdata;
      end
      if (en) begin
        rd_r <= mem[raddr];
      end
    end

    assign rdata[b] = rd_r;
  end

endmodule

FILE: rtl/core/bis_blend.sv
// Per-lane weighted blend of four neighbours: product stage, then sum and round.
// Depends on bis_pkg.
module bis_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  bis_pkg::blend_ctl_t ctl_in,
  input  bis_pkg::wquad_t     wgt,
  input  bis_pkg::quad_t      pix,
  output bis_pkg::blend_ctl_t ctl_out,
  output bis_pkg::pixel_t     pixel
);
  import bis_pkg::*;

  localparam int PRD_W = WGT_W + LANE_W;
  localparam int ACC_W = PRD_W + 2;
  localparam int SHIFT = 2 * FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);
  localparam logic [ACC_W-SHIFT-1:0] LANE_MAX = (ACC_W-SHIFT)'((1 << LANE_W) - 1);

  blend_ctl_t       prd_ctl_r;
  logic [PRD_W-1:0] prod_r [LANES][4];
  blend_ctl_t       out_ctl_r;
  pixel_t           pixel_r;
  pixel_t           pixel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_ctl_r <= '0;
      out_ctl_r <= '0;
    end else if (en) begin
      prd_ctl_r <= ctl_in;
      out_ctl_r <= prd_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < 4; k++) begin
          prod_r[l][k] <= PRD_W'(wgt[k]) * PRD_W'(pix[k][l*LANE_W +: LANE_W]);
        end
      end
      pixel_r <= pixel_nxt;
    end
  end

  // Sum, round half up, drop the fraction, saturate; zero the pixel on error.
  always_comb begin
    logic [ACC_W-1:0]       acc;
    logic [ACC_W-SHIFT-1:0] v;
    pixel_nxt = '0;
    for (int l = 0; l < LANES; l++) begin
      acc = ACC_W'(prod_r[l][0]) + ACC_W'(prod_r[l][1]) + ACC_W'(prod_r[l][2])
          + ACC_W'(prod_r[l][3]) + HALF;
      v = acc[ACC_W-1:SHIFT];
      if (v > LANE_MAX) begin
        v = LANE_MAX;
      end
      if (!prd_ctl_r.err) begin
        pixel_nxt[l*LANE_W +: LANE_W] = v[LANE_W-1:0];
      end
    end
  end

  assign ctl_out = out_ctl_r;
  assign pixel   = pixel_r;

endmodule
